/* rtl/max_pool_2d_stream_defines.svh */
// ----------------------------------------------------------------------------
// max_pool_2d_stream_defines
// Assertion macros shared by the max pooling block
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_STREAM_DEFINES_SVH
`define MAX_POOL_2D_STREAM_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define MP2D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define MP2D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mp2d_pkg.sv */
// ----------------------------------------------------------------------------
// mp2d_pkg
// Widths, register codes, reset values and shared types of the max pooling block
// ----------------------------------------------------------------------------
package mp2d_pkg;

    // item and result field widths
    localparam int SAMPLE_W = 16;
    localparam int OROW_W   = 10;
    localparam int OCOL_W   = 7;
    localparam int CHAN_W   = 6;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_HEIGHT = 3'd0,
        CFG_IN_WIDTH  = 3'd1,
        CFG_CHANNELS  = 3'd2,
        CFG_POOL_ROWS = 3'd3,
        CFG_POOL_COLS = 3'd4,
        CFG_OUT_ROWS  = 3'd5,
        CFG_OUT_COLS  = 3'd6
    } t_cfg_idx;

    // register widths
    localparam int IN_HEIGHT_W = 11;
    localparam int IN_WIDTH_W  = 8;
    localparam int CHANNELS_W  = 7;
    localparam int POOL_REG_W  = 4;
    localparam int OUT_ROWS_W  = 11;
    localparam int OUT_COLS_W  = 8;

    // register reset values
    localparam logic [IN_HEIGHT_W-1:0] IN_HEIGHT_RST = 11'd1;
    localparam logic [IN_WIDTH_W-1:0]  IN_WIDTH_RST  = 8'd1;
    localparam logic [CHANNELS_W-1:0]  CHANNELS_RST  = 7'd1;
    localparam logic [POOL_REG_W-1:0]  POOL_ROWS_RST = 4'd2;
    localparam logic [POOL_REG_W-1:0]  POOL_COLS_RST = 4'd2;
    localparam logic [OUT_ROWS_W-1:0]  OUT_ROWS_RST  = 11'd1;
    localparam logic [OUT_COLS_W-1:0]  OUT_COLS_RST  = 8'd1;

    // row range of the map
    localparam int ROW_LIMIT = 1024;
    localparam int ROW_W     = 10;

    // parameter defaults
    localparam int MAX_WIDTH_DEF    = 128;
    localparam int MAX_CHANNELS_DEF = 64;
    localparam int MAX_POOL_DEF     = 8;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;

    // per-item control travelling from front to back
    typedef struct packed {
        logic first;
        logic emit;
        logic frame_last;
    } t_flags;

    // index width of a range of n values, at least one bit
    function automatic int clog2_min1(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

/* rtl/mp2d_if.sv */
// ----------------------------------------------------------------------------
// mp2d_if
// Valid/ready channels of the max pooling block: samples, results, register writes
// ----------------------------------------------------------------------------

// sample channel
interface mp2d_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [mp2d_pkg::SAMPLE_W-1:0]       sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// result channel
interface mp2d_out_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [mp2d_pkg::SAMPLE_W-1:0]       max_value;
    logic        [mp2d_pkg::OROW_W-1:0]         out_row;
    logic        [mp2d_pkg::OCOL_W-1:0]         out_col;
    logic        [mp2d_pkg::CHAN_W-1:0]         channel;
    logic                                       frame_last;

    modport source (output valid, output max_value, output out_row, output out_col,
                    output channel, output frame_last, input ready);
    modport sink   (input valid, input max_value, input out_row, input out_col,
                    input channel, input frame_last, output ready);
endinterface

// register write channel
interface mp2d_cfg_if;
    logic                                       valid;
    logic                                       ready;
    logic [mp2d_pkg::CFG_IDX_W-1:0]             index;
    logic [mp2d_pkg::CFG_DATA_W-1:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/mp2d_ram.sv */
// ----------------------------------------------------------------------------
// mp2d_ram
// Simple dual-port RAM, one write and one registered read port
// ----------------------------------------------------------------------------
module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [mp2d_pkg::clog2_min1(DEPTH)-1:0]       i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [mp2d_pkg::clog2_min1(DEPTH)-1:0]       i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mp2d_fifo.sv */
// ----------------------------------------------------------------------------
// mp2d_fifo
// Short register queue that decouples the classifier from the update pipe
// ----------------------------------------------------------------------------
module mp2d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = mp2d_pkg::clog2_min1(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // pointer and fill level update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* rtl/mp2d_div.sv */
// ----------------------------------------------------------------------------
// mp2d_div
// Restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mp2d_div #(
    parameter int DVD_W = 10,
    parameter int DVS_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] n_cnt;
    logic [DVD_W-1:0] n_q;
    logic [DVS_W-1:0] n_rem;
    logic [DVS_W-1:0] n_dvs;
    logic [DVS_W:0]   partial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // one trial subtraction per step
    always_comb begin
        partial = {r_rem, r_q[DVD_W-1]};
        diff    = partial - {1'b0, r_dvs};
        fits    = (partial >= {1'b0, r_dvs});
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_cnt = CNT_W'(DVD_W);
            n_q   = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_q   = DVD_W'({r_q, fits});
            n_rem = fits ? DVS_W'(diff) : DVS_W'(partial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy      = (r_cnt != '0);
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

/* rtl/mp2d_front.sv */
// ----------------------------------------------------------------------------
// mp2d_front
// Registers, map position tracking and window classification of each item
// ----------------------------------------------------------------------------
`include "max_pool_2d_stream_defines.svh"

module mp2d_front #(
    parameter int MAX_WIDTH    = mp2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp2d_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_POOL     = mp2d_pkg::MAX_POOL_DEF,
    parameter int ENTRY_W      = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mp2d_cfg_if.sink           i_cfg,
    mp2d_in_if.sink            i_in,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output logic [ENTRY_W-1:0] o_push_data
);

    localparam int ROW_W  = mp2d_pkg::ROW_W;
    localparam int COL_W  = mp2d_pkg::clog2_min1(MAX_WIDTH);
    localparam int CH_W   = mp2d_pkg::clog2_min1(MAX_CHANNELS);
    localparam int POOL_W = mp2d_pkg::clog2_min1(MAX_POOL);
    localparam int DVS_W  = POOL_W + 1;
    localparam int ADDR_W = mp2d_pkg::clog2_min1(MAX_WIDTH * MAX_CHANNELS);

    // configuration registers
    logic [mp2d_pkg::IN_HEIGHT_W-1:0] r_in_height;
    logic [mp2d_pkg::IN_WIDTH_W-1:0]  r_in_width;
    logic [mp2d_pkg::CHANNELS_W-1:0]  r_channels;
    logic [mp2d_pkg::POOL_REG_W-1:0]  r_pool_rows;
    logic [mp2d_pkg::POOL_REG_W-1:0]  r_pool_cols;
    logic [mp2d_pkg::OUT_ROWS_W-1:0]  r_out_rows;
    logic [mp2d_pkg::OUT_COLS_W-1:0]  r_out_cols;

    // position of the next item
    logic [ROW_W-1:0]  r_row,  n_row;
    logic [COL_W-1:0]  r_col,  n_col;
    logic [CH_W-1:0]   r_chan, n_chan;
    logic [POOL_W-1:0] r_rsub, n_rsub;
    logic [POOL_W-1:0] r_csub, n_csub;
    logic [ROW_W-1:0]  r_orow, n_orow;
    logic [COL_W-1:0]  r_ocol, n_ocol;

    // window position resync after a pool size change
    logic r_sync_start;
    logic r_sync_pend;
    logic n_sync_pend;

    // clamped last indexes
    logic [ROW_W-1:0]  hm1;
    logic [COL_W-1:0]  wm1;
    logic [CH_W-1:0]   ncm1;
    logic [POOL_W-1:0] prm1;
    logic [POOL_W-1:0] pcm1;

    logic              cfg_acc;
    logic              pool_wr;
    logic              in_acc;
    logic              stale;
    logic              sync_load;
    logic [ROW_W-1:0]  c_row;
    logic [COL_W-1:0]  c_col;
    logic [CH_W-1:0]   c_chan;
    logic [POOL_W-1:0] c_rsub;
    logic [POOL_W-1:0] c_csub;
    logic [ROW_W-1:0]  c_orow;
    logic [COL_W-1:0]  c_ocol;
    logic              covered;
    logic              last_row;
    logic              last_col;
    logic              row_edge;
    logic              col_edge;
    mp2d_pkg::t_flags  flags;
    logic [ADDR_W-1:0] addr;

    logic              row_busy;
    logic              col_busy;
    logic [ROW_W-1:0]  row_quot;
    logic [DVS_W-1:0]  row_rem;
    logic [COL_W-1:0]  col_quot;
    logic [DVS_W-1:0]  col_rem;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign pool_wr     = cfg_acc && ((i_cfg.index == mp2d_pkg::CFG_POOL_ROWS) ||
                                     (i_cfg.index == mp2d_pkg::CFG_POOL_COLS));
    assign i_in.ready  = !r_sync_pend && i_push_ready;
    assign in_acc      = i_in.valid && i_in.ready;

    // register clamping
    always_comb begin
        if (r_in_height == '0) begin
            hm1 = '0;
        end else if (r_in_height > mp2d_pkg::IN_HEIGHT_W'(mp2d_pkg::ROW_LIMIT)) begin
            hm1 = ROW_W'(mp2d_pkg::ROW_LIMIT - 1);
        end else begin
            hm1 = ROW_W'(r_in_height - mp2d_pkg::IN_HEIGHT_W'(1));
        end
        if (r_in_width == '0) begin
            wm1 = '0;
        end else if (32'(r_in_width) > MAX_WIDTH) begin
            wm1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            wm1 = COL_W'(r_in_width - mp2d_pkg::IN_WIDTH_W'(1));
        end
        if (r_channels == '0) begin
            ncm1 = '0;
        end else if (32'(r_channels) > MAX_CHANNELS) begin
            ncm1 = CH_W'(MAX_CHANNELS - 1);
        end else begin
            ncm1 = CH_W'(r_channels - mp2d_pkg::CHANNELS_W'(1));
        end
        if (r_pool_rows == '0) begin
            prm1 = '0;
        end else if (32'(r_pool_rows) > MAX_POOL) begin
            prm1 = POOL_W'(MAX_POOL - 1);
        end else begin
            prm1 = POOL_W'(r_pool_rows - mp2d_pkg::POOL_REG_W'(1));
        end
        if (r_pool_cols == '0) begin
            pcm1 = '0;
        end else if (32'(r_pool_cols) > MAX_POOL) begin
            pcm1 = POOL_W'(MAX_POOL - 1);
        end else begin
            pcm1 = POOL_W'(r_pool_cols - mp2d_pkg::POOL_REG_W'(1));
        end
    end

    // item classification
    always_comb begin
        stale  = (r_row > hm1) || (r_col > wm1) || (r_chan > ncm1);
        c_row  = stale ? '0 : r_row;
        c_col  = stale ? '0 : r_col;
        c_chan = stale ? '0 : r_chan;
        c_rsub = stale ? '0 : r_rsub;
        c_csub = stale ? '0 : r_csub;
        c_orow = stale ? '0 : r_orow;
        c_ocol = stale ? '0 : r_ocol;

        covered  = (mp2d_pkg::OUT_ROWS_W'(c_orow) < r_out_rows) &&
                   (11'(c_ocol) < 11'(r_out_cols));
        row_edge = (c_rsub == prm1);
        col_edge = (c_csub == pcm1);
        last_row = row_edge || (c_row == hm1);
        last_col = col_edge || (c_col == wm1);

        flags.first      = (c_rsub == '0) && (c_csub == '0);
        flags.emit       = last_row && last_col;
        flags.frame_last = ((mp2d_pkg::OUT_ROWS_W'(c_orow) ==
                             r_out_rows - mp2d_pkg::OUT_ROWS_W'(1)) || (c_row == hm1)) &&
                           ((11'(c_ocol) == 11'(r_out_cols) - 11'd1) || (c_col == wm1)) &&
                           (c_chan == ncm1);
        addr = ADDR_W'(32'(c_ocol) * MAX_CHANNELS) + ADDR_W'(c_chan);
    end

    assign o_push_valid = in_acc && covered;
    assign o_push_data  = {flags, i_in.sample, c_orow, mp2d_pkg::OCOL_W'(c_ocol),
                           mp2d_pkg::CHAN_W'(c_chan), addr};

    // position advance and resync load
    always_comb begin
        sync_load = r_sync_pend && !r_sync_start && !row_busy && !col_busy;
        n_row  = r_row;
        n_col  = r_col;
        n_chan = r_chan;
        n_rsub = r_rsub;
        n_csub = r_csub;
        n_orow = r_orow;
        n_ocol = r_ocol;
        if (in_acc) begin
            n_row  = c_row;
            n_col  = c_col;
            n_rsub = c_rsub;
            n_csub = c_csub;
            n_orow = c_orow;
            n_ocol = c_ocol;
            if (c_chan != ncm1) begin
                n_chan = c_chan + CH_W'(1);
            end else begin
                n_chan = '0;
                if (c_col != wm1) begin
                    n_col  = c_col + COL_W'(1);
                    n_csub = col_edge ? '0 : c_csub + POOL_W'(1);
                    n_ocol = col_edge ? c_ocol + COL_W'(1) : c_ocol;
                end else begin
                    n_col  = '0;
                    n_csub = '0;
                    n_ocol = '0;
                    if (c_row != hm1) begin
                        n_row  = c_row + ROW_W'(1);
                        n_rsub = row_edge ? '0 : c_rsub + POOL_W'(1);
                        n_orow = row_edge ? c_orow + ROW_W'(1) : c_orow;
                    end else begin
                        n_row  = '0;
                        n_rsub = '0;
                        n_orow = '0;
                    end
                end
            end
        end else if (sync_load) begin
            n_orow = row_quot;
            n_rsub = POOL_W'(row_rem);
            n_ocol = col_quot;
            n_csub = POOL_W'(col_rem);
        end
        if (pool_wr) begin
            n_sync_pend = 1'b1;
        end else if (sync_load) begin
            n_sync_pend = 1'b0;
        end else begin
            n_sync_pend = r_sync_pend;
        end
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height  <= mp2d_pkg::IN_HEIGHT_RST;
            r_in_width   <= mp2d_pkg::IN_WIDTH_RST;
            r_channels   <= mp2d_pkg::CHANNELS_RST;
            r_pool_rows  <= mp2d_pkg::POOL_ROWS_RST;
            r_pool_cols  <= mp2d_pkg::POOL_COLS_RST;
            r_out_rows   <= mp2d_pkg::OUT_ROWS_RST;
            r_out_cols   <= mp2d_pkg::OUT_COLS_RST;
            r_row        <= '0;
            r_col        <= '0;
            r_chan       <= '0;
            r_rsub       <= '0;
            r_csub       <= '0;
            r_orow       <= '0;
            r_ocol       <= '0;
            r_sync_start <= 1'b0;
            r_sync_pend  <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg.index)
                    mp2d_pkg::CFG_IN_HEIGHT: r_in_height <= i_cfg.data;
                    mp2d_pkg::CFG_IN_WIDTH:
                        r_in_width  <= i_cfg.data[mp2d_pkg::IN_WIDTH_W-1:0];
                    mp2d_pkg::CFG_CHANNELS:
                        r_channels  <= i_cfg.data[mp2d_pkg::CHANNELS_W-1:0];
                    mp2d_pkg::CFG_POOL_ROWS:
                        r_pool_rows <= i_cfg.data[mp2d_pkg::POOL_REG_W-1:0];
                    mp2d_pkg::CFG_POOL_COLS:
                        r_pool_cols <= i_cfg.data[mp2d_pkg::POOL_REG_W-1:0];
                    mp2d_pkg::CFG_OUT_ROWS:  r_out_rows  <= i_cfg.data;
                    mp2d_pkg::CFG_OUT_COLS:
                        r_out_cols  <= i_cfg.data[mp2d_pkg::OUT_COLS_W-1:0];
                    default: ;
                endcase
            end
            r_row        <= n_row;
            r_col        <= n_col;
            r_chan       <= n_chan;
            r_rsub       <= n_rsub;
            r_csub       <= n_csub;
            r_orow       <= n_orow;
            r_ocol       <= n_ocol;
            r_sync_start <= pool_wr;
            r_sync_pend  <= n_sync_pend;
        end
    end

    // window coordinates of the current position under the new pool sizes
    mp2d_div #(
        .DVD_W (ROW_W),
        .DVS_W (DVS_W)
    ) u_row_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_sync_start),
        .i_dividend  (r_row),
        .i_divisor   (DVS_W'(prm1) + DVS_W'(1)),
        .o_busy      (row_busy),
        .o_quotient  (row_quot),
        .o_remainder (row_rem)
    );

    mp2d_div #(
        .DVD_W (COL_W),
        .DVS_W (DVS_W)
    ) u_col_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_sync_start),
        .i_dividend  (r_col),
        .i_divisor   (DVS_W'(pcm1) + DVS_W'(1)),
        .o_busy      (col_busy),
        .o_quotient  (col_quot),
        .o_remainder (col_rem)
    );

    // checks
    `MP2D_ASSERT_IMP(a_no_item_in_resync, in_acc, !r_sync_pend, "item taken during resync")
    `MP2D_ASSERT_NXT(a_pos_in_map, in_acc, (r_chan <= $past(ncm1)) && (r_col <= $past(wm1)), "position left the map")
    `MP2D_ASSERT_IMP(a_sub_in_window, !r_sync_pend && !r_sync_start, (r_rsub <= prm1) && (r_csub <= pcm1), "window offset past pool size")

endmodule

/* rtl/mp2d_back.sv */
// ----------------------------------------------------------------------------
// mp2d_back
// Running maximum update through the column/channel store and result register
// ----------------------------------------------------------------------------
`include "max_pool_2d_stream_defines.svh"

module mp2d_back #(
    parameter int MAX_WIDTH    = mp2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp2d_pkg::MAX_CHANNELS_DEF,
    parameter int ENTRY_W      = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  logic [ENTRY_W-1:0] i_pop_data,
    mp2d_out_if.source         o_out
);

    localparam int SAMPLE_W = mp2d_pkg::SAMPLE_W;
    localparam int DEPTH    = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W   = mp2d_pkg::clog2_min1(DEPTH);

    // update stage
    logic                       r_s1_v;
    logic [ENTRY_W-1:0]         r_s1;
    mp2d_pkg::t_flags           s1_flags;
    logic signed [SAMPLE_W-1:0] s1_sample;
    logic [mp2d_pkg::OROW_W-1:0] s1_orow;
    logic [mp2d_pkg::OCOL_W-1:0] s1_ocol;
    logic [mp2d_pkg::CHAN_W-1:0] s1_chan;
    logic [ADDR_W-1:0]          s1_addr;

    // queue head address
    logic [ADDR_W-1:0]          h_addr;

    // last write, for a read that raced it
    logic                       r_fwd_v;
    logic [ADDR_W-1:0]          r_fwd_addr;
    logic signed [SAMPLE_W-1:0] r_fwd_data;

    // result register
    logic                       r_out_v;
    logic signed [SAMPLE_W-1:0] r_out_max;
    logic [mp2d_pkg::OROW_W-1:0] r_out_row;
    logic [mp2d_pkg::OCOL_W-1:0] r_out_col;
    logic [mp2d_pkg::CHAN_W-1:0] r_out_chan;
    logic                       r_out_last;

    logic                       out_free;
    logic                       s1_go;
    logic                       pop;
    logic                       hit;
    logic [SAMPLE_W-1:0]        rd_data;
    logic signed [SAMPLE_W-1:0] cur_max;
    logic signed [SAMPLE_W-1:0] new_max;

    assign h_addr                                                      = i_pop_data[ADDR_W-1:0];
    assign {s1_flags, s1_sample, s1_orow, s1_ocol, s1_chan, s1_addr}   = r_s1;

    // stage handshakes
    assign out_free    = !r_out_v || o_out.ready;
    assign s1_go       = r_s1_v && (!s1_flags.emit || out_free);
    assign o_pop_ready = !r_s1_v || s1_go;
    assign pop         = i_pop_valid && o_pop_ready;

    // compare and select
    always_comb begin
        hit     = r_fwd_v && (r_fwd_addr == s1_addr);
        cur_max = hit ? r_fwd_data : $signed(rd_data);
        if (s1_flags.first || (s1_sample > cur_max)) begin
            new_max = s1_sample;
        end else begin
            new_max = cur_max;
        end
    end

    mp2d_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_max_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (s1_addr),
        .i_wdata (new_max),
        .i_re    (pop),
        .i_raddr (h_addr),
        .o_rdata (rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_fwd_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (pop) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go) begin
                r_fwd_v <= 1'b1;
            end
            if (s1_go && s1_flags.emit) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1 <= i_pop_data;
        end
        if (s1_go) begin
            r_fwd_addr <= s1_addr;
            r_fwd_data <= new_max;
        end
        if (s1_go && s1_flags.emit) begin
            r_out_max  <= new_max;
            r_out_row  <= s1_orow;
            r_out_col  <= s1_ocol;
            r_out_chan <= s1_chan;
            r_out_last <= s1_flags.frame_last;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.max_value  = r_out_max;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_col    = r_out_col;
    assign o_out.channel    = r_out_chan;
    assign o_out.frame_last = r_out_last;

    // checks
    `MP2D_ASSERT_IMP(a_max_ge_sample, s1_go, new_max >= s1_sample,
                     "stored maximum below its item")
    `MP2D_ASSERT_IMP(a_max_no_drop, s1_go && !s1_flags.first && hit,
                     new_max >= r_fwd_data, "running maximum dropped")
    `MP2D_ASSERT_NXT(a_pop_lands, pop, r_s1_v, "popped item lost before update")

endmodule

/* rtl/max_pool_2d_stream.sv */
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Non-overlapping 2D max pooling over a channel-innermost sample stream.
// Throughput: one item per cycle unless a resync is pending or the queue is
// full; running maxima live in a one-port-read RAM. A write to pool_rows or
// pool_cols holds off items while the serial divider resyncs the window
// position. Reset is synchronous: registers, position and handshakes clear;
// the running-maximum RAM is not cleared.
// ----------------------------------------------------------------------------
module max_pool_2d_stream #(
    parameter int MAX_WIDTH    = mp2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp2d_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_POOL     = mp2d_pkg::MAX_POOL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mp2d_cfg_if.sink   i_cfg,
    mp2d_in_if.sink    i_in,
    mp2d_out_if.source o_out
);

    localparam int ADDR_W  = mp2d_pkg::clog2_min1(MAX_WIDTH * MAX_CHANNELS);
    localparam int ENTRY_W = $bits(mp2d_pkg::t_flags) + mp2d_pkg::SAMPLE_W +
                             mp2d_pkg::OROW_W + mp2d_pkg::OCOL_W + mp2d_pkg::CHAN_W +
                             ADDR_W;

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    // classifier
    mp2d_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_POOL     (MAX_POOL),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // decoupling queue
    mp2d_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (mp2d_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push_valid),
        .o_ready (push_ready),
        .i_data  (push_data),
        .o_valid (pop_valid),
        .i_ready (pop_ready),
        .o_data  (pop_data)
    );

    // maximum update and result
    mp2d_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out       (o_out)
    );

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives feature maps through max_pool_2d_stream with random handshake gaps,
// predicts every window maximum with its coordinates and frame-end flag, and
// checks each result in order against the predicted ones
// ----------------------------------------------------------------------------
module testbench;
    import mp2d_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] max_value;
        logic [OROW_W-1:0]          out_row;
        logic [OCOL_W-1:0]          out_col;
        logic [CHAN_W-1:0]          channel;
        logic                       frame_last;
    } pool_result_t;

    typedef enum int {MIX_WIDE, MIX_NEGATIVE, MIX_CLOSE} sample_mix_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mp2d_cfg_if reg_ch ();
    mp2d_in_if  sample_ch ();
    mp2d_out_if result_ch ();

    max_pool_2d_stream DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (reg_ch),
        .i_in    (sample_ch),
        .o_out   (result_ch)
    );

    // register copies, window position and running maxima of the predictor
    logic [IN_HEIGHT_W-1:0]     cfg_in_height;
    logic [IN_WIDTH_W-1:0]      cfg_in_width;
    logic [CHANNELS_W-1:0]      cfg_channels;
    logic [POOL_REG_W-1:0]      cfg_pool_rows;
    logic [POOL_REG_W-1:0]      cfg_pool_cols;
    logic [OUT_ROWS_W-1:0]      cfg_out_rows;
    logic [OUT_COLS_W-1:0]      cfg_out_cols;
    int                         row_pos;
    int                         col_pos;
    int                         chan_pos;
    logic signed [SAMPLE_W-1:0] window_max [MAX_WIDTH_DEF*MAX_CHANNELS_DEF];

    pool_result_t pending_maxima [$];
    int           error_count;
    int           quiet_cycles;
    int           ready_stall;
    bit           no_idle;

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    function automatic int clamp_to(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int frame_len(input int h, input int w, input int c);
        return clamp_to(h, 1, ROW_LIMIT) * clamp_to(w, 1, MAX_WIDTH_DEF)
            * clamp_to(c, 1, MAX_CHANNELS_DEF);
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int draw;
        draw = $urandom_range(0, 99);
        if (draw < 70) return 0;
        if (draw < 95) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_mix_t mix);
        int draw;
        draw = $urandom_range(0, 15);
        case (mix)
            MIX_NEGATIVE: return SAMPLE_W'($urandom) | 16'h8000;
            MIX_CLOSE:    return SAMPLE_W'($urandom_range(0, 6) - 3);
            default: begin
                if (draw == 0) return 16'sh8000;
                if (draw == 1) return 16'sh7FFF;
                if (draw == 2) return 16'sh0000;
                if (draw == 3) return 16'shFFFF;
                return SAMPLE_W'($urandom);
            end
        endcase
    endfunction

    task automatic predictor_reset();
        cfg_in_height = IN_HEIGHT_RST;
        cfg_in_width  = IN_WIDTH_RST;
        cfg_channels  = CHANNELS_RST;
        cfg_pool_rows = POOL_ROWS_RST;
        cfg_pool_cols = POOL_COLS_RST;
        cfg_out_rows  = OUT_ROWS_RST;
        cfg_out_cols  = OUT_COLS_RST;
        row_pos  = 0;
        col_pos  = 0;
        chan_pos = 0;
    endtask

    // one sample into the window maxima; returns 1 when a covered window closes
    function automatic bit predict_pool(input logic signed [SAMPLE_W-1:0] x,
                                        output pool_result_t res);
        int h, w, nc, pr, pc, r, c, ch, orow, ocol, idx, lastr, lastc;
        bit closes;
        h  = clamp_to(cfg_in_height, 1, ROW_LIMIT);
        w  = clamp_to(cfg_in_width, 1, MAX_WIDTH_DEF);
        nc = clamp_to(cfg_channels, 1, MAX_CHANNELS_DEF);
        pr = clamp_to(cfg_pool_rows, 1, MAX_POOL_DEF);
        pc = clamp_to(cfg_pool_cols, 1, MAX_POOL_DEF);
        closes = 1'b0;
        res = '0;

        // position left outside the map by a register write
        if (row_pos >= h || col_pos >= w || chan_pos >= nc) begin
            row_pos  = 0;
            col_pos  = 0;
            chan_pos = 0;
        end
        r  = row_pos;
        c  = col_pos;
        ch = chan_pos;
        orow = r / pr;
        ocol = c / pc;

        // covered windows: first sample loads, later ones keep the larger
        if (orow < int'(cfg_out_rows) && ocol < int'(cfg_out_cols)) begin
            idx = ocol * MAX_CHANNELS_DEF + ch;
            if (r % pr == 0 && c % pc == 0)
                window_max[idx] = x;
            else if (x > window_max[idx])
                window_max[idx] = x;
            closes = ((r % pr == pr - 1) || (r == h - 1))
                && ((c % pc == pc - 1) || (c == w - 1));
            if (closes) begin
                lastr = clamp_to((h + pr - 1) / pr, 0, cfg_out_rows) - 1;
                lastc = clamp_to((w + pc - 1) / pc, 0, cfg_out_cols) - 1;
                res.max_value  = window_max[idx];
                res.out_row    = OROW_W'(orow);
                res.out_col    = OCOL_W'(ocol);
                res.channel    = CHAN_W'(ch);
                res.frame_last = (orow == lastr && ocol == lastc && ch == nc - 1);
            end
        end

        // advance channel, column, row; wrap at frame end
        if (ch + 1 < nc) begin
            chan_pos = ch + 1;
        end else begin
            chan_pos = 0;
            if (c + 1 < w) begin
                col_pos = c + 1;
            end else begin
                col_pos = 0;
                row_pos = (r + 1 < h) ? r + 1 : 0;
            end
        end
        return closes;
    endfunction

    // one item on the sample channel, prediction on acceptance
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        pool_result_t res;
        gap = no_idle ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= x;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
        if (predict_pool(x, res))
            pending_maxima.push_back(res);
    endtask

    // drain all results and let the pipeline empty
    task automatic settle_block();
        @(negedge i_clk);
        sample_ch.valid <= 1'b0;
        while (pending_maxima.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        @(negedge i_clk);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (reg_ch.ready !== 1'b1);
        case (idx)
            CFG_IN_HEIGHT: cfg_in_height = IN_HEIGHT_W'(val);
            CFG_IN_WIDTH:  cfg_in_width  = IN_WIDTH_W'(val);
            CFG_CHANNELS:  cfg_channels  = CHANNELS_W'(val);
            CFG_POOL_ROWS: cfg_pool_rows = POOL_REG_W'(val);
            CFG_POOL_COLS: cfg_pool_cols = POOL_REG_W'(val);
            CFG_OUT_ROWS:  cfg_out_rows  = OUT_ROWS_W'(val);
            CFG_OUT_COLS:  cfg_out_cols  = OUT_COLS_W'(val);
            default: ;
        endcase
        @(negedge i_clk);
        reg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input int h, input int w, input int c, input int pr,
                              input int pc, input int orows, input int ocols);
        write_reg(CFG_IN_HEIGHT, h);
        write_reg(CFG_IN_WIDTH, w);
        write_reg(CFG_CHANNELS, c);
        write_reg(CFG_POOL_ROWS, pr);
        write_reg(CFG_POOL_COLS, pc);
        write_reg(CFG_OUT_ROWS, orows);
        write_reg(CFG_OUT_COLS, ocols);
    endtask

    task automatic run_frame(input sample_mix_t mix);
        int n;
        n = frame_len(cfg_in_height, cfg_in_width, cfg_channels);
        repeat (n) send_sample(pick_sample(mix));
    endtask

    // reset values: every item is a whole 1x1 map inside a clipped 2x2 window
    task automatic test_reset_state();
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
    endtask

    // 3x3 map in 2x2 windows, all negative so the maximum cannot start at zero
    task automatic test_clipped_windows();
        settle_block();
        set_config(3, 3, 1, 2, 2, 2, 2);
        for (int i = 0; i < 9; i++)
            send_sample((i == 8) ? 16'sh8000 : SAMPLE_W'(-(i + 1) * 1000));
    endtask

    // zero registers clamp to one; zero output coverage gives nothing
    task automatic test_zero_registers();
        settle_block();
        set_config(0, 0, 0, 0, 0, 0, 0);
        send_sample(16'sh1234);
        send_sample(16'shFEDC);
        settle_block();
        write_reg(CFG_OUT_ROWS, 1);
        send_sample(16'sh0100);
        settle_block();
        write_reg(CFG_OUT_COLS, 1);
        send_sample(16'sh8001);
    endtask

    // oversized registers, restart of a position left outside the map,
    // and coverage narrowed in the middle of a frame
    task automatic test_stale_position();
        settle_block();
        set_config(2047, 255, 127, 15, 15, 2047, 255);
        repeat (20) send_sample(pick_sample(MIX_WIDE));
        settle_block();
        set_config(3, 3, 2, 2, 2, 2, 2);
        run_frame(MIX_WIDE);
        settle_block();
        set_config(4, 4, 1, 2, 2, 2, 2);
        repeat (10) send_sample(pick_sample(MIX_WIDE));
        settle_block();
        write_reg(CFG_OUT_COLS, 1);
        repeat (6) send_sample(pick_sample(MIX_WIDE));
    endtask

    // random shapes, mostly small, a few at the register extremes
    task automatic test_random_frames();
        int h, w, c, pr, pc, orows, ocols, draw, frames, sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            draw = $urandom_range(0, 19);
            h  = $urandom_range(1, 8);
            w  = $urandom_range(1, 10);
            c  = $urandom_range(1, 4);
            pr = $urandom_range(1, 8);
            pc = $urandom_range(1, 8);
            if (draw == 0) begin
                pr = $urandom_range(0, 15);
                pc = $urandom_range(0, 15);
            end else if (draw == 1) begin
                h = 1;
                w = $urandom_range(100, 255);
                c = 1;
            end else if (draw == 2) begin
                h = 1;
                w = $urandom_range(1, 2);
                c = $urandom_range(40, 127);
            end else if (draw == 3) begin
                h  = $urandom_range(20, 60);
                w  = 1;
                c  = 1;
                pr = 8;
            end else if (draw == 4) begin
                h = 0;
                w = $urandom_range(0, 3);
                c = 0;
            end

            draw = $urandom_range(0, 9);
            if (draw == 0)
                orows = 0;
            else if (draw == 1)
                orows = $urandom_range(1024, 2047);
            else
                orows = $urandom_range(1, h + 1);
            draw = $urandom_range(0, 9);
            if (draw == 0)
                ocols = 0;
            else if (draw == 1)
                ocols = $urandom_range(128, 255);
            else
                ocols = $urandom_range(1, (w < 255) ? w + 1 : 255);

            settle_block();
            set_config(h, w, c, pr, pc, orows, ocols);
            frames = $urandom_range(1, 2);
            repeat (frames) begin
                no_idle = ($urandom_range(0, 3) == 0);
                run_frame(sample_mix_t'($urandom_range(0, 2)));
                sent += frame_len(h, w, c);
            end
        end
        no_idle = 1'b0;
    endtask

    // result side stalls
    always @(negedge i_clk) begin
        if (ready_stall > 0) begin
            result_ch.ready <= 1'b0;
            ready_stall--;
        end else begin
            result_ch.ready <= 1'b1;
            if (!no_idle)
                ready_stall = pick_gap();
        end
    end

    // compare each result with the oldest predicted one
    always @(posedge i_clk) begin : result_check
        pool_result_t want;
        if (i_rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_maxima.size() == 0) begin
                report_mismatch($sformatf("result with none pending: row %0d col %0d ch %0d",
                    result_ch.out_row, result_ch.out_col, result_ch.channel));
            end else begin
                want = pending_maxima.pop_front();
                if (result_ch.max_value !== want.max_value)
                    report_mismatch($sformatf("max_value got %0d expected %0d",
                        result_ch.max_value, want.max_value));
                if (result_ch.out_row !== want.out_row)
                    report_mismatch($sformatf("out_row got %0d expected %0d",
                        result_ch.out_row, want.out_row));
                if (result_ch.out_col !== want.out_col)
                    report_mismatch($sformatf("out_col got %0d expected %0d",
                        result_ch.out_col, want.out_col));
                if (result_ch.channel !== want.channel)
                    report_mismatch($sformatf("channel got %0d expected %0d",
                        result_ch.channel, want.channel));
                if (result_ch.frame_last !== want.frame_last)
                    report_mismatch($sformatf("frame_last got %0b expected %0b",
                        result_ch.frame_last, want.frame_last));
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready)
                || (result_ch.valid && result_ch.ready) || (reg_ch.valid && reg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n          = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        reg_ch.valid     = 1'b0;
        reg_ch.index     = CFG_IN_HEIGHT;
        reg_ch.data      = '0;
        result_ch.ready  = 1'b0;
        ready_stall      = 0;
        no_idle          = 1'b0;
        error_count      = 0;
        quiet_cycles     = 0;
        predictor_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_clipped_windows();
        test_zero_registers();
        test_stale_position();
        test_random_frames();

        settle_block();
        if (pending_maxima.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_maxima.size()));
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
